@@ hw/rtl/dmm_pkg.sv @@
// Shared types and codes for the dense matrix multiply core.
package dmm_pkg;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [2:0] REG_A_ROWS      = 3'd0;
  localparam logic [2:0] REG_A_COLS      = 3'd1;
  localparam logic [2:0] REG_B_ROWS      = 3'd2;
  localparam logic [2:0] REG_B_COLS      = 3'd3;
  localparam logic [2:0] REG_TRANSPOSE_A = 3'd4;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int ACC_W       = 67;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         elem_index;
    logic signed [31:0] elem_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         result_row;
    logic [2:0]         result_col;
    logic               last;
    logic               dim_error;
  } result_t;

  // Per-term tag that follows a store read down the datapath.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last_k;
    logic       last_elem;
    logic [2:0] row;
    logic [2:0] col;
  } tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

endpackage

@@ hw/rtl/dense_matrix_multiply_core.sv @@
// Dense matrix multiply core: operand stores, term sequencer and MAC datapath.
//
// Usage: one command transfer per cycle on item while busy is low (start high).
//   cmd LOAD_A / LOAD_B writes elem_value into the A or B store at elem_index;
//   loads produce no result. cmd START forms L * B, L being A or A transposed
//   per transpose_a, dimensions from the config registers (cfg_we, cfg_index,
//   cfg_data; no read-back; the user writes only while idle, not enforced).
// Results: one transfer per element on result while result_valid is high for
//   one cycle, row-major, last set on the final one. The receiver cannot stall.
//   An inner-dimension mismatch gives a single result with dim_error and last
//   set, in the cycle after the start transfer; else a zero size gives nothing.
// Timing: a product run issues one store read pair per term; the terms pass
//   the read, multiply and accumulate stages, and each finished sum the
//   round/saturate stage before it appears on result. busy stays high until
//   the last term has left the accumulator; loads never raise busy.
// Reset: config returns to 8 x 8 by 8 x 8, no transpose; the sequencer idles.
//   Store contents are undefined until loaded; no clearing pass is run.
module dense_matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dmm_pkg::item_t    item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  output logic              result_valid,
  output dmm_pkg::result_t  result
);

  localparam logic [3:0] DIM_CAP = 4'(MAX_DIM);

  // ---------------- configuration registers ----------------
  logic [3:0] a_rows, a_cols, b_rows, b_cols;
  logic       transpose_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows      <= 4'd8;
      a_cols      <= 4'd8;
      b_rows      <= 4'd8;
      b_cols      <= 4'd8;
      transpose_a <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == dmm_pkg::REG_A_ROWS)      a_rows      <= cfg_data;
      if (cfg_index == dmm_pkg::REG_A_COLS)      a_cols      <= cfg_data;
      if (cfg_index == dmm_pkg::REG_B_ROWS)      b_rows      <= cfg_data;
      if (cfg_index == dmm_pkg::REG_B_COLS)      b_cols      <= cfg_data;
      if (cfg_index == dmm_pkg::REG_TRANSPOSE_A) transpose_a <= cfg_data[0];
    end
  end

  // Oversized dimensions fold to the cap before any check.
  logic [3:0] ar, ac, br, bc, nrows, inner;
  assign ar    = (a_rows > DIM_CAP) ? DIM_CAP : a_rows;
  assign ac    = (a_cols > DIM_CAP) ? DIM_CAP : a_cols;
  assign br    = (b_rows > DIM_CAP) ? DIM_CAP : b_rows;
  assign bc    = (b_cols > DIM_CAP) ? DIM_CAP : b_cols;
  assign nrows = transpose_a ? ac : ar;
  assign inner = transpose_a ? ar : ac;

  logic accept, start_cmd, mismatch, zero_dim, go;
  assign accept    = start && !busy;
  assign start_cmd = accept && (item.cmd == dmm_pkg::CMD_START);
  assign mismatch  = (inner != br);
  assign zero_dim  = (ar == 4'd0) || (ac == 4'd0) || (br == 4'd0) || (bc == 4'd0);
  assign go        = start_cmd && !mismatch && !zero_dim;

  // ---------------- sequencer ----------------
  dmm_pkg::seq_state_t st, st_next;
  logic [2:0] i_cnt, j_cnt, k_cnt;
  logic [2:0] i_cnt_next, j_cnt_next, k_cnt_next;
  logic [3:0] nrows_r, bc_r, inner_r, ac_r;
  logic       tr_r;
  logic       k_last, j_last, i_last, issue;
  logic       s1_busy;

  assign k_last = ({1'b0, k_cnt} + 4'd1) == inner_r;
  assign j_last = ({1'b0, j_cnt} + 4'd1) == bc_r;
  assign i_last = ({1'b0, i_cnt} + 4'd1) == nrows_r;

  always_comb begin
    st_next = st;
    unique case (st)
      dmm_pkg::ST_IDLE: if (go) st_next = dmm_pkg::ST_RUN;
      dmm_pkg::ST_RUN:  if (k_last && j_last && i_last) st_next = dmm_pkg::ST_IDLE;
      default:          st_next = dmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    issue = (st == dmm_pkg::ST_RUN);
    busy  = issue || s1_busy;
  end

  always_comb begin
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    k_cnt_next = k_cnt;
    if (!issue) begin
      i_cnt_next = 3'd0;
      j_cnt_next = 3'd0;
      k_cnt_next = 3'd0;
    end else if (!k_last) begin
      k_cnt_next = k_cnt + 3'd1;
    end else begin
      k_cnt_next = 3'd0;
      if (!j_last) begin
        j_cnt_next = j_cnt + 3'd1;
      end else begin
        j_cnt_next = 3'd0;
        i_cnt_next = i_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= dmm_pkg::ST_IDLE;
      i_cnt <= 3'd0;
      j_cnt <= 3'd0;
      k_cnt <= 3'd0;
    end else begin
      st    <= st_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      k_cnt <= k_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      nrows_r <= nrows;
      bc_r    <= bc;
      inner_r <= inner;
      ac_r    <= ac;
      tr_r    <= transpose_a;
    end
  end

  // Row-major store addresses of the current term.
  logic [6:0] a_lin, b_lin;
  logic [dmm_pkg::ADDR_W-1:0] a_addr, b_addr;
  assign a_lin  = tr_r ? (7'(k_cnt) * 7'(ac_r) + 7'(i_cnt))
                       : (7'(i_cnt) * 7'(ac_r) + 7'(k_cnt));
  assign b_lin  = 7'(k_cnt) * 7'(bc_r) + 7'(j_cnt);
  assign a_addr = a_lin[dmm_pkg::ADDR_W-1:0];
  assign b_addr = b_lin[dmm_pkg::ADDR_W-1:0];

  // ---------------- operand stores ----------------
  logic signed [31:0] a_mem [dmm_pkg::STORE_DEPTH];
  logic signed [31:0] b_mem [dmm_pkg::STORE_DEPTH];
  logic signed [31:0] a_q, b_q;
  logic load_a, load_b;
  assign load_a = accept && (item.cmd == dmm_pkg::CMD_LOAD_A);
  assign load_b = accept && (item.cmd == dmm_pkg::CMD_LOAD_B);

  always_ff @(posedge clk) begin
    if (load_a) a_mem[item.elem_index] <= item.elem_value;
    a_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (load_b) b_mem[item.elem_index] <= item.elem_value;
    b_q <= b_mem[b_addr];
  end

  // ---------------- MAC datapath ----------------
  dmm_pkg::tag_t tag0, s1, s2, s3;
  logic signed [63:0]               prod;
  logic signed [dmm_pkg::ACC_W-1:0] acc;

  always_comb begin
    tag0.valid     = issue;
    tag0.first     = (k_cnt == 3'd0);
    tag0.last_k    = k_last;
    tag0.last_elem = k_last && j_last && i_last;
    tag0.row       = i_cnt;
    tag0.col       = j_cnt;
  end

  assign s1_busy = s1.valid || s2.valid || s3.valid;

  // Only the valid bits are reset; the rest of each tag rides along freely.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else begin
      s1.valid <= tag0.valid;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
    end
    {s1.first, s1.last_k, s1.last_elem, s1.row, s1.col} <=
      {tag0.first, tag0.last_k, tag0.last_elem, tag0.row, tag0.col};
    {s2.first, s2.last_k, s2.last_elem, s2.row, s2.col} <=
      {s1.first, s1.last_k, s1.last_elem, s1.row, s1.col};
    {s3.first, s3.last_k, s3.last_elem, s3.row, s3.col} <=
      {s2.first, s2.last_k, s2.last_elem, s2.row, s2.col};
    prod <= a_q * b_q;
    if (s2.valid) begin
      acc <= s2.first ? dmm_pkg::ACC_W'(prod) : acc + dmm_pkg::ACC_W'(prod);
    end
  end

  // Round to nearest, ties up, then saturate to Q16.16.
  logic signed [dmm_pkg::ACC_W-1:0] rnd;
  logic signed [31:0]               sat;
  logic                             fits;
  assign rnd  = acc + dmm_pkg::ACC_W'(32768);
  assign fits = (rnd[dmm_pkg::ACC_W-1:47] == {(dmm_pkg::ACC_W-47){rnd[47]}});
  always_comb begin
    if (fits)                        sat = rnd[47:16];
    else if (rnd[dmm_pkg::ACC_W-1])  sat = 32'sh8000_0000;
    else                             sat = 32'sh7FFF_FFFF;
  end

  // ---------------- result register ----------------
  logic err_out, mac_out;
  assign err_out = start_cmd && mismatch;
  assign mac_out = s3.valid && s3.last_k;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= err_out || mac_out;
  end

  // err_out needs busy low and mac_out needs busy high, so they never meet.
  always_ff @(posedge clk) begin
    if (mac_out) begin
      result.result_value <= sat;
      result.result_row   <= s3.row;
      result.result_col   <= s3.col;
      result.last         <= s3.last_elem;
      result.dim_error    <= 1'b0;
    end else if (err_out) begin
      result.result_value <= 32'sd0;
      result.result_row   <= 3'd0;
      result.result_col   <= 3'd0;
      result.last         <= 1'b1;
      result.dim_error    <= 1'b1;
    end
  end

  // ---------------- assertions ----------------
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (st == dmm_pkg::ST_RUN) |-> busy)
    else $error("sequencer running while busy is low");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    err_out |=> (result_valid && result.dim_error && result.last))
    else $error("mismatch start did not give a single error result");

  a_mac_result: assert property (@(posedge clk) disable iff (rst)
    mac_out |=> (result_valid && !result.dim_error))
    else $error("finished sum did not reach the result port");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(err_out && s1_busy))
    else $error("error result collides with a run in flight");

endmodule
